[src/can_signal_field_decoder_macros.svh]
// ----------------------------------------------------------------------------
// can_signal_field_decoder_macros
// Assertion shorthands shared by the checker of the signal field decoder.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_FIELD_DECODER_MACROS_SVH
`define CAN_SIGNAL_FIELD_DECODER_MACROS_SVH

// same-cycle implication, off during reset
`define CSFD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("csfd: check failed");

// next-cycle implication, off during reset
`define CSFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("csfd: check failed");

// next-cycle implication that also runs during reset
`define CSFD_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("csfd: check failed");

`endif

[src/csfd_pkg.sv]
// ----------------------------------------------------------------------------
// csfd_pkg
// Types and constants shared by the signal field decoder modules.
// ----------------------------------------------------------------------------
package csfd_pkg;

   localparam int PAYLOAD_BYTES = 8;
   localparam int FIELD_BYTES   = 8;
   localparam int NB_MAX        = (PAYLOAD_BYTES < FIELD_BYTES) ? PAYLOAD_BYTES : FIELD_BYTES;

   localparam logic [6:0] MAX_LEN = 7'd64;

   localparam int REQ_TDATA_W = 72;   // payload, payload_bytes, zero fill
   localparam int RSP_TDATA_W = 192;  // raw, signed, physical

   localparam logic [63:0] PHYS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] PHYS_MIN = 64'h8000_0000_0000_0000;

   localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

   typedef enum logic [2:0] {
      CSR_START_BIT     = 3'd0,
      CSR_SIGNAL_LENGTH = 3'd1,
      CSR_SIGNED_MODE   = 3'd2,
      CSR_BYTE_ORDER    = 3'd3,
      CSR_SCALE_FACTOR  = 3'd4,
      CSR_OFFSET_VALUE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [5:0]  first_bit;
      logic [6:0]  signal_length;
      logic        signed_mode;
      logic        byte_order;
      logic [31:0] scale_factor;
      logic [63:0] offset_value;
   } cfg_type;

   // extraction result handed to the arithmetic pipe
   typedef struct packed {
      logic [63:0] raw_value;
      logic [63:0] signed_value;
      logic [63:0] magnitude;
      logic [31:0] scale_mag;
      logic        negate;
   } ext_type;

   typedef struct packed {
      logic [63:0] raw_value;
      logic [63:0] signed_value;
      logic [63:0] physical_value;
      logic        saturated;
   } rsp_type;

   // byte reversal; big-endian stream order becomes a plain left shift
   function automatic logic [63:0] bswap64(input logic [63:0] d);
      logic [63:0] r;
      for (int b = 0; b < 8; b++) begin
         r[b*8 +: 8] = d[(7-b)*8 +: 8];
      end
      return r;
   endfunction

endpackage

[src/csfd_csr.sv]
// ----------------------------------------------------------------------------
// csfd_csr
// Configuration register file: start bit, length, mode, order, scale, offset.
// ----------------------------------------------------------------------------
module csfd_csr import csfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_wdata,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_BIT:     cfg_in.first_bit     = csr_wdata[5:0];
            CSR_SIGNAL_LENGTH: cfg_in.signal_length = csr_wdata[6:0];
            CSR_SIGNED_MODE:   cfg_in.signed_mode   = csr_wdata[0];
            CSR_BYTE_ORDER:    cfg_in.byte_order    = csr_wdata[0];
            CSR_SCALE_FACTOR:  cfg_in.scale_factor  = csr_wdata[31:0];
            CSR_OFFSET_VALUE:  cfg_in.offset_value  = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_bit     <= '0;
         cfg_ff.signal_length <= '0;
         cfg_ff.signed_mode   <= 1'b0;
         cfg_ff.byte_order    <= 1'b0;
         cfg_ff.scale_factor  <= SCALE_RESET;
         cfg_ff.offset_value  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/csfd_extract.sv]
// ----------------------------------------------------------------------------
// csfd_extract
// Three-stage bit extraction: align, mask/collapse, sign-extend and magnitude.
// ----------------------------------------------------------------------------
module csfd_extract import csfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [63:0]   in_payload,
   input  logic [3:0]    in_nbytes,
   output logic          out_valid,
   input  logic          out_ready,
   output ext_type       out_item
);

   logic s1_en, s2_en, s3_en;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;

   // stage 1: drop invalid bytes, align to start bit
   logic [3:0]  nb;
   logic [63:0] byte_mask;
   logic [63:0] masked;
   logic [6:0]  len_eff;
   logic [6:0]  valid_bits;
   logic [7:0]  span_end;
   logic [7:0]  span_lim;
   logic [6:0]  take;
   logic [63:0] s1_shift_in;
   logic [63:0] s1_shift_ff;
   logic [6:0]  s1_len_ff;
   logic [6:0]  s1_take_ff;

   // stage 2: raw value
   logic [63:0] s2_raw_in;
   logic [63:0] s2_raw_ff;
   logic [6:0]  s2_len_ff;

   // stage 3: sign and magnitude
   logic        top_bit;
   logic        do_ext;
   logic [63:0] sval;
   logic        vneg;
   logic        sneg;
   ext_type     s3_in;
   ext_type     s3_ff;

   assign s3_en    = !s3_valid_ff || out_ready;
   assign s2_en    = !s2_valid_ff || s3_en;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_ready = s1_en;

   always_comb begin
      nb = (in_nbytes > 4'(NB_MAX)) ? 4'(NB_MAX) : in_nbytes;
      for (int b = 0; b < 8; b++) begin
         byte_mask[b*8 +: 8] = (4'(b) < nb) ? 8'hFF : 8'h00;
      end
      masked     = in_payload & byte_mask;
      len_eff    = (cfg.signal_length > MAX_LEN) ? MAX_LEN : cfg.signal_length;
      valid_bits = {nb[3:0], 3'b000};
      span_end   = {2'b00, cfg.first_bit} + {1'b0, len_eff};
      span_lim   = (span_end < {1'b0, valid_bits}) ? span_end : {1'b0, valid_bits};
      // bits actually shifted in for stream order
      take       = (span_lim > {2'b00, cfg.first_bit}) ?
                   7'(span_lim - {2'b00, cfg.first_bit}) : 7'd0;
      if (cfg.byte_order)
         s1_shift_in = bswap64(masked) << cfg.first_bit;
      else
         s1_shift_in = masked >> cfg.first_bit;
   end

   always_comb begin
      if (cfg.byte_order)
         s2_raw_in = s1_shift_ff >> (MAX_LEN - s1_take_ff);
      else
         s2_raw_in = s1_shift_ff & ~({64{1'b1}} << s1_len_ff);
   end

   always_comb begin
      top_bit = s2_raw_ff[6'(s2_len_ff - 7'd1)];
      do_ext  = cfg.signed_mode && (s2_len_ff != 7'd0) && (s2_len_ff < MAX_LEN) && top_bit;
      sval    = do_ext ? (s2_raw_ff | ({64{1'b1}} << s2_len_ff)) : s2_raw_ff;
      vneg    = cfg.signed_mode && sval[63];
      sneg    = cfg.scale_factor[31];
      s3_in.raw_value    = s2_raw_ff;
      s3_in.signed_value = sval;
      s3_in.magnitude    = vneg ? (~sval + 64'd1) : sval;
      s3_in.scale_mag    = sneg ? (~cfg.scale_factor + 32'd1) : cfg.scale_factor;
      s3_in.negate       = vneg ^ sneg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= in_valid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_shift_ff <= s1_shift_in;
         s1_len_ff   <= len_eff;
         s1_take_ff  <= take;
      end
      if (s2_en) begin
         s2_raw_ff <= s2_raw_in;
         s2_len_ff <= s1_len_ff;
      end
      if (s3_en) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_ff;

endmodule

[src/csfd_arith.sv]
// ----------------------------------------------------------------------------
// csfd_arith
// Four-stage scaling: partial products, product sum, offset, saturation.
// ----------------------------------------------------------------------------
module csfd_arith import csfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  ext_type       in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output rsp_type       out_item
);

   logic s4_en, s5_en, s6_en, s7_en;
   logic s4_valid_ff, s5_valid_ff, s6_valid_ff, s7_valid_ff;

   // stage 4: two 32x32 partial products
   logic [63:0] s4_p0_ff, s4_p1_ff;
   logic [63:0] s4_raw_ff, s4_sval_ff;
   logic        s4_neg_ff;

   // stage 5: 96-bit magnitude product
   logic [95:0] s5_prod_in;
   logic [95:0] s5_prod_ff;
   logic [63:0] s5_raw_ff, s5_sval_ff;
   logic        s5_neg_ff;

   // stage 6: signed sum with offset
   logic [97:0] off_ext;
   logic [97:0] prod_ext;
   logic [97:0] s6_sum_in;
   logic [97:0] s6_sum_ff;
   logic [63:0] s6_raw_ff, s6_sval_ff;

   // stage 7: saturate
   logic        sat;
   rsp_type     s7_in;
   rsp_type     s7_ff;

   assign s7_en    = !s7_valid_ff || out_ready;
   assign s6_en    = !s6_valid_ff || s7_en;
   assign s5_en    = !s5_valid_ff || s6_en;
   assign s4_en    = !s4_valid_ff || s5_en;
   assign in_ready = s4_en;

   assign s5_prod_in = {32'd0, s4_p0_ff} + {s4_p1_ff, 32'd0};

   always_comb begin
      off_ext   = {{34{cfg.offset_value[63]}}, cfg.offset_value};
      prod_ext  = {2'b00, s5_prod_ff};
      s6_sum_in = s5_neg_ff ? (off_ext - prod_ext) : (off_ext + prod_ext);
   end

   always_comb begin
      // in range only when bits 97..63 are all copies of the sign
      sat = !((&s6_sum_ff[97:63]) || !(|s6_sum_ff[97:63]));
      s7_in.raw_value      = s6_raw_ff;
      s7_in.signed_value   = s6_sval_ff;
      s7_in.saturated      = sat;
      if (sat)
         s7_in.physical_value = s6_sum_ff[97] ? PHYS_MIN : PHYS_MAX;
      else
         s7_in.physical_value = s6_sum_ff[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         if (s4_en) s4_valid_ff <= in_valid;
         if (s5_en) s5_valid_ff <= s4_valid_ff;
         if (s6_en) s6_valid_ff <= s5_valid_ff;
         if (s7_en) s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_p0_ff   <= {32'd0, in_item.magnitude[31:0]} * {32'd0, in_item.scale_mag};
         s4_p1_ff   <= {32'd0, in_item.magnitude[63:32]} * {32'd0, in_item.scale_mag};
         s4_raw_ff  <= in_item.raw_value;
         s4_sval_ff <= in_item.signed_value;
         s4_neg_ff  <= in_item.negate;
      end
      if (s5_en) begin
         s5_prod_ff <= s5_prod_in;
         s5_raw_ff  <= s4_raw_ff;
         s5_sval_ff <= s4_sval_ff;
         s5_neg_ff  <= s4_neg_ff;
      end
      if (s6_en) begin
         s6_sum_ff  <= s6_sum_in;
         s6_raw_ff  <= s5_raw_ff;
         s6_sval_ff <= s5_sval_ff;
      end
      if (s7_en) begin
         s7_ff <= s7_in;
      end
   end

   assign out_valid = s7_valid_ff;
   assign out_item  = s7_ff;

endmodule

[src/can_signal_field_decoder.sv]
// ----------------------------------------------------------------------------
// can_signal_field_decoder
// Extracts one configured signal from a frame payload and scales it.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one word per frame: payload and its valid byte count.
//   rsp_* : one word per frame: raw, sign-extended and physical value,
//           with the saturation flag on rsp_tuser.
//   csr_* : register writes (start bit, length, signed mode, byte order,
//           scale Q16.16, offset Q48.16); csr_ready is always high.
//           Write only while no frame is in flight.
// A word accepted on req passes through three extraction stages and four
// arithmetic stages (two 32x32 partial products, product sum, offset add,
// saturation). Throughput is one frame per cycle while rsp_tready is high;
// every stage has its own valid bit.
// When rsp_tready is low the output word holds and the stages behind it
// keep filling empty slots, so req_tready drops only once every stage is
// occupied. Reset clears all valid bits and loads the register defaults
// (scale 1.0, everything else zero); no word is lost or repeated on a stall.
// ----------------------------------------------------------------------------
module can_signal_field_decoder import csfd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_TDATA_W-1:0]   req_tdata,   // payload[63:0], payload_bytes[67:64]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_TDATA_W-1:0]   rsp_tdata,   // raw_value, signed_value, physical_value
   output logic                     rsp_tuser,   // saturated
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [63:0]              csr_wdata
);

   cfg_type cfg;
   logic    ext_valid;
   logic    ext_ready;
   ext_type ext_item;
   rsp_type rsp_item;

   csfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   csfd_extract u_extract (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_payload (req_tdata[63:0]),
      .in_nbytes  (req_tdata[67:64]),
      .out_valid  (ext_valid),
      .out_ready  (ext_ready),
      .out_item   (ext_item)
   );

   csfd_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (ext_valid),
      .in_ready  (ext_ready),
      .in_item   (ext_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tdata = {rsp_item.physical_value, rsp_item.signed_value, rsp_item.raw_value};
   assign rsp_tuser = rsp_item.saturated;

endmodule

[src/csfd_checker.sv]
// ----------------------------------------------------------------------------
// csfd_checker
// Port-level checks on the signal field decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "can_signal_field_decoder_macros.svh"

module csfd_checker import csfd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                     rsp_tuser
);

   logic [63:0] raw_word;
   logic [63:0] sext_word;
   logic [63:0] phys_word;
   logic        word_stall;
   logic        sext_diff;
   logic        sext_ok;

   assign raw_word   = rsp_tdata[63:0];
   assign sext_word  = rsp_tdata[127:64];
   assign phys_word  = rsp_tdata[191:128];
   assign word_stall = rsp_tvalid && !rsp_tready;
   assign sext_diff  = rsp_tvalid && (sext_word != raw_word);
   assign sext_ok    = sext_word[63] && ((sext_word & raw_word) == raw_word);

   // pipeline empties on reset
   `CSFD_ASSERT_NEXT_ALWAYS(a_reset_flush, reset, !rsp_tvalid)

   // a stalled result word holds
   `CSFD_ASSERT_NEXT(a_rsp_hold, word_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // clipping lands on one of the two rails
   `CSFD_ASSERT_NOW(a_sat_rail, rsp_tvalid && rsp_tuser, (phys_word == PHYS_MIN) || (phys_word == PHYS_MAX))

   // sign extension only sets upper bits, and only for a negative value
   `CSFD_ASSERT_NOW(a_sext, sext_diff, sext_ok)

endmodule

bind can_signal_field_decoder csfd_checker u_csfd_checker (.*);
